[rtl/ipv4_route_prefix_lookup_assert.svh]
// Assertion macros for the route prefix lookup block.
// Included by files that check their own logic; needs no package.
`ifndef IPV4_ROUTE_PREFIX_LOOKUP_ASSERT_SVH
`define IPV4_ROUTE_PREFIX_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RPL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen outside reset.
`define RPL_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RPL_ASSERT(lbl, clk, rst, prop, msg)
`define RPL_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

[rtl/rpl_pkg.sv]
// Shared types, constants and functions of the route prefix lookup block.
// Used by the channel interfaces and every module of the block but rpl_ram.
package rpl_pkg;

  // Fixed field widths of the channels.
  localparam int ADDR_BITS      = 32;
  localparam int LEN_BITS       = 6;
  localparam int IDX_BITS       = 4;
  localparam int HOP_FIELD_BITS = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_HOP_BITS      = 8;

  // Longest prefix length; written lengths saturate here.
  localparam logic [LEN_BITS-1:0] PREFIX_LEN_MAX = LEN_BITS'(ADDR_BITS);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

  // One classified command; key is the lookup address or the written prefix.
  typedef struct packed {
    op_t                       op;
    logic [ADDR_BITS-1:0]      key;
    logic [IDX_BITS-1:0]       idx;
    logic [LEN_BITS-1:0]       len;
    logic [HOP_FIELD_BITS-1:0] hop;
    logic                      enable;
  } cmd_t;

  // Queue activity, watched by the checks at the top level.
  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 push;
    logic                 pop;
  } q_status_t;

  // Mask that keeps the top len bits of an address, for len 0 to 32.
  function automatic logic [ADDR_BITS-1:0] top_mask(input logic [LEN_BITS-1:0] len);
    logic [ADDR_BITS-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

[rtl/rpl_if.sv]
// Channel interfaces of the route prefix lookup block: request, result, config.
// Field widths come from rpl_pkg.
interface rpl_in_if import rpl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [ADDR_BITS-1:0]      dest_addr;
  logic [IDX_BITS-1:0]       entry_index;
  logic [ADDR_BITS-1:0]      entry_prefix;
  logic [LEN_BITS-1:0]       entry_length;
  logic [HOP_FIELD_BITS-1:0] entry_hop;
  logic                      entry_enable;

  modport source (output valid, operation, dest_addr, entry_index, entry_prefix,
                  entry_length, entry_hop, entry_enable, input ready);
  modport sink (input valid, operation, dest_addr, entry_index, entry_prefix,
                entry_length, entry_hop, entry_enable, output ready);
endinterface

interface rpl_out_if import rpl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [HOP_FIELD_BITS-1:0] next_hop;
  logic                      matched;
  logic [LEN_BITS-1:0]       match_length;

  modport source (output valid, next_hop, matched, match_length, input ready);
  modport sink (input valid, next_hop, matched, match_length, output ready);
endinterface

interface rpl_cfg_if import rpl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [HOP_FIELD_BITS-1:0] default_hop;

  modport source (output valid, default_hop, input ready);
  modport sink (input valid, default_hop, output ready);
endinterface

[rtl/rpl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module rpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rpl_front.sv]
// Front end: accepts request transfers and turns them into queue commands.
// Depends on rpl_pkg and the rpl_in_if interface.
module rpl_front import rpl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  rpl_in_if.sink req,
  input  logic   q_ready,
  output logic   push,
  output cmd_t   cmd
);

  logic is_write;
  logic drop;

  // A request is taken whenever the queue has room.
  assign req.ready = q_ready;

  // Writes to a slot beyond the table are taken but not queued.
  assign is_write = (req.operation == OP_WRITE);
  assign drop     = is_write && (int'(req.entry_index) >= TABLE_ENTRIES);
  assign push     = req.valid && q_ready && !drop;

  // Build the command; lengths above the address width saturate.
  always_comb begin
    cmd.op     = is_write ? OP_WRITE : OP_LOOKUP;
    cmd.key    = is_write ? req.entry_prefix : req.dest_addr;
    cmd.idx    = req.entry_index;
    cmd.len    = (req.entry_length > PREFIX_LEN_MAX) ? PREFIX_LEN_MAX : req.entry_length;
    cmd.hop    = req.entry_hop;
    cmd.enable = req.entry_enable;
  end

endmodule

[rtl/rpl_queue.sv]
// Short command queue that decouples the front end from the lookup engine.
// Depends on rpl_pkg for the command type and depth.
module rpl_queue import rpl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  output logic      ready,
  output logic      head_valid,
  output cmd_t      head,
  input  logic      pop,
  output q_status_t status
);

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign ready      = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  assign status.count = count;
  assign status.push  = push;
  assign status.pop   = pop;

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/rpl_back.sv]
// Back end: executes table writes and scans the route RAM for lookups.
// Depends on rpl_pkg, rpl_ram and the rpl_out_if interface.
module rpl_back import rpl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int HOP_BITS      = DEF_HOP_BITS,
  parameter int HOP_W         = (HOP_BITS < HOP_FIELD_BITS) ? HOP_BITS : HOP_FIELD_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cmd_t             head,
  output logic             pop,
  input  logic [HOP_W-1:0] default_hop,
  rpl_out_if.source        rsp
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int WORD_W = ADDR_BITS + LEN_BITS + HOP_W;

  back_state_t state, state_next;

  logic [TABLE_ENTRIES-1:0] valid;
  logic [CNT_W-1:0]         iss;
  logic                     pv;
  logic [IDX_W-1:0]         pidx;
  logic [ADDR_BITS-1:0]     dest;
  logic                     found;
  logic [LEN_BITS-1:0]      best_len;
  logic [HOP_W-1:0]         best_hop;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]    ram_rdata;

  logic [ADDR_BITS-1:0] e_prefix;
  logic [LEN_BITS-1:0]  e_len;
  logic [HOP_W-1:0]     e_hop;
  logic                 hit;
  logic                 take;
  logic                 last;
  logic                 more;
  logic                 load;

  // One RAM word per route: prefix, length, hop.
  rpl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = IDX_W'(head.idx);
  assign ram_wdata = {head.key, head.len, head.hop[HOP_W-1:0]};

  // Compare the entry read in the previous cycle against the destination.
  assign e_prefix = ram_rdata[WORD_W-1 -: ADDR_BITS];
  assign e_len    = ram_rdata[HOP_W +: LEN_BITS];
  assign e_hop    = ram_rdata[HOP_W-1:0];
  assign hit      = pv && valid[pidx] && (((dest ^ e_prefix) & top_mask(e_len)) == '0);
  assign take     = hit && (!found || (e_len > best_len));
  assign last     = pv && (pidx == IDX_W'(TABLE_ENTRIES - 1));
  assign more     = (iss < CNT_W'(TABLE_ENTRIES));

  // Next state, queue pop and RAM control.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            ram_re     = 1'b1;
            state_next = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (more) begin
          ram_re    = 1'b1;
          ram_raddr = iss[IDX_W-1:0];
        end
        if (last) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State register and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      valid <= '0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        valid[ram_waddr] <= head.enable;
      end
    end
  end

  // Scan pointers and best-match tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (state == BK_IDLE && pop && head.op == OP_LOOKUP) begin
      dest     <= head.key;
      iss      <= CNT_W'(1);
      pv       <= 1'b1;
      pidx     <= '0;
      found    <= 1'b0;
      best_len <= '0;
    end else if (state == BK_SCAN) begin
      if (take) begin
        found    <= 1'b1;
        best_len <= e_len;
        best_hop <= e_hop;
      end
      pv <= more;
      if (more) begin
        pidx <= iss[IDX_W-1:0];
        iss  <= iss + 1'b1;
      end
    end
  end

  // Result register; holds until the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.next_hop     <= found ? HOP_FIELD_BITS'(best_hop) : HOP_FIELD_BITS'(default_hop);
      rsp.matched      <= found;
      rsp.match_length <= found ? best_len : '0;
    end
  end

endmodule

[rtl/ipv4_route_prefix_lookup.sv]
// Top level of the IPv4 longest-prefix route lookup block.
// Depends on rpl_pkg, rpl_if, rpl_front, rpl_queue, rpl_back and the assert header.

// The block keeps a table of TABLE_ENTRIES routes in a RAM and answers each
// lookup with the valid route of the longest matching prefix, the lowest slot
// winning a tie, or with default_hop when nothing matches. Request transfers
// go into a two-deep command queue, so the front accepts up to two items
// ahead of the engine. A write item is done in the idle state and returns
// no result. A lookup reads the first route from the idle state, then the
// scan reads one route per cycle from the single RAM read port, and the done
// state loads the result register when the result channel is free. The
// valid bits are flip-flops cleared by reset, so the block is ready right
// after reset. default_hop is set through the always-ready config channel.
`include "ipv4_route_prefix_lookup_assert.svh"

module ipv4_route_prefix_lookup import rpl_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int HOP_BITS      = DEF_HOP_BITS
) (
  input  logic      clk,
  input  logic      rst,
  rpl_in_if.sink    req,
  rpl_out_if.source rsp,
  rpl_cfg_if.sink   cfg
);

  localparam int HOP_W = (HOP_BITS < HOP_FIELD_BITS) ? HOP_BITS : HOP_FIELD_BITS;

  logic [HOP_W-1:0] default_hop;
  logic             push;
  cmd_t             push_cmd;
  logic             q_ready;
  logic             head_valid;
  cmd_t             head;
  logic             pop;
  q_status_t        q_stat;

  // Config register, masked to the hop width.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_hop <= '0;
    end else if (cfg.valid) begin
      default_hop <= cfg.default_hop[HOP_W-1:0];
    end
  end

  rpl_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .req     (req),
    .q_ready (q_ready),
    .push    (push),
    .cmd     (push_cmd)
  );

  rpl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .status     (q_stat)
  );

  rpl_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HOP_BITS      (HOP_BITS),
    .HOP_W         (HOP_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .default_hop (default_hop),
    .rsp         (rsp)
  );

  // Checks on the queue and the result register.
  `RPL_ASSERT(a_len_bound, clk, rst, rsp.valid |-> (rsp.match_length <= PREFIX_LEN_MAX), "match length above 32")
  `RPL_ASSERT(a_nomatch_len, clk, rst, (rsp.valid && !rsp.matched) |-> (rsp.match_length == '0), "unmatched result has nonzero length")
  `RPL_NEVER(a_pop_empty, clk, rst, q_stat.pop && (q_stat.count == '0), "pop from empty command queue")
  `RPL_NEVER(a_q_over, clk, rst, q_stat.count > QCNT_BITS'(QUEUE_DEPTH), "command queue overfilled")
  `RPL_ASSERT(a_q_grow, clk, rst, (q_stat.push && !q_stat.pop) |=> (q_stat.count == QCNT_BITS'($past(q_stat.count) + 1'b1)), "queue count did not advance on push")

endmodule
